// ===== rtl/csv_line_field_splitter_unit_assert.svh =====
// Assertion macros shared by the CSV line field splitter modules.
`ifndef CSV_LINE_FIELD_SPLITTER_UNIT_ASSERT_SVH
`define CSV_LINE_FIELD_SPLITTER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define CSVFS_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("csvfs assertion failed");
`define CSVFS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("csvfs assertion failed");
`else
`define CSVFS_ASSERT_IMPLY(label, clk, rstn, ante, cons)
`define CSVFS_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/csvfs_pkg.sv =====
// Package with the types and constants of the CSV line field splitter.
`timescale 1ns / 1ps
package csvfs_pkg;

    localparam int MAX_COLUMNS_DEFAULT = 32;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [7:0] BACKSLASH_CODE = 8'h5C;

    localparam logic [7:0] SEPARATOR_RESET = 8'd44;
    localparam logic [7:0] QUOTE_RESET     = 8'd34;
    localparam logic       CHECK_RESET     = 1'b1;
    localparam logic [5:0] EXPECTED_RESET  = 6'd1;

    typedef enum logic [1:0] {
        KIND_CHAR      = 2'd0,
        KIND_FIELD_END = 2'd1,
        KIND_LINE_END  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        CFG_SEPARATOR = 2'd0,
        CFG_QUOTE     = 2'd1,
        CFG_CHECK     = 2'd2,
        CFG_EXPECTED  = 2'd3
    } cfg_idx_t;

    // One classified input item: up to two single results, a run of padding
    // field ends and an optional line end, emitted in that order.
    typedef struct packed {
        logic       s0_v;
        kind_t      s0_kind;
        logic [7:0] s0_char;
        logic       s1_v;
        kind_t      s1_kind;
        logic [7:0] s1_char;
        logic [4:0] idx;
        logic [5:0] pad_cnt;
        logic [4:0] pad_idx;
        logic       line_end;
        logic       quote_err;
    } cmd_t;

endpackage

// ===== rtl/csvfs_front.sv =====
// Front end: configuration registers, parser state and item classification.
`timescale 1ns / 1ps
module csvfs_front #(
    parameter int MAX_COLUMNS = csvfs_pkg::MAX_COLUMNS_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_addr,
    input  logic [7:0]        cfg_wdata,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_char,
    input  logic              s_eol,
    input  logic              q_full_i,
    output logic              push_o,
    output csvfs_pkg::cmd_t   cmd_o
);

    localparam int CAP = (MAX_COLUMNS < 32) ? MAX_COLUMNS : 32;
    localparam logic [5:0] CAP_W = 6'(CAP);

    logic [7:0] sep_reg, quote_reg;
    logic       check_reg;
    logic [5:0] expected_reg;

    logic       in_quotes_reg, in_quotes_next;
    logic       esc_reg, esc_next;
    logic [5:0] fc_reg, fc_next;
    logic       started_reg, started_next;

    logic [5:0] eff_exp;
    logic       kept;
    logic [4:0] cur_idx;
    logic       accept;
    logic       has_results;
    csvfs_pkg::cmd_t cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sep_reg      <= csvfs_pkg::SEPARATOR_RESET;
            quote_reg    <= csvfs_pkg::QUOTE_RESET;
            check_reg    <= csvfs_pkg::CHECK_RESET;
            expected_reg <= csvfs_pkg::EXPECTED_RESET;
        end else if (cfg_wr_en) begin
            unique case (csvfs_pkg::cfg_idx_t'(cfg_addr))
                csvfs_pkg::CFG_SEPARATOR: sep_reg      <= cfg_wdata;
                csvfs_pkg::CFG_QUOTE:     quote_reg    <= cfg_wdata;
                csvfs_pkg::CFG_CHECK:     check_reg    <= cfg_wdata[0];
                csvfs_pkg::CFG_EXPECTED:  expected_reg <= cfg_wdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (expected_reg == 6'd0) begin
            eff_exp = 6'd1;
        end else if (expected_reg > CAP_W) begin
            eff_exp = CAP_W;
        end else begin
            eff_exp = expected_reg;
        end
    end

    assign kept     = !check_reg || (fc_reg < eff_exp);
    assign cur_idx  = (fc_reg > 6'd31) ? 5'd31 : fc_reg[4:0];
    assign s_tready = !q_full_i;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        logic                 do_plain;
        logic                 p_v;
        csvfs_pkg::kind_t     p_kind;
        logic [7:0]           p_char;
        logic [6:0]           fc_plus;
        logic                 no_err;

        do_plain = 1'b0;
        p_v      = 1'b0;
        p_kind   = csvfs_pkg::KIND_CHAR;
        p_char   = 8'd0;
        fc_plus  = {1'b0, fc_reg} + 7'd1;
        no_err   = !in_quotes_reg;

        cmd            = '0;
        cmd.s0_kind    = csvfs_pkg::KIND_CHAR;
        cmd.s1_kind    = csvfs_pkg::KIND_CHAR;
        cmd.idx        = cur_idx;
        in_quotes_next = in_quotes_reg;
        esc_next       = esc_reg;
        fc_next        = fc_reg;
        started_next   = started_reg;

        if (!s_eol) begin
            started_next = 1'b1;
            do_plain     = 1'b1;
            if (esc_reg) begin
                esc_next    = 1'b0;
                cmd.s0_v    = kept;
                cmd.s0_kind = csvfs_pkg::KIND_CHAR;
                if (s_char == quote_reg || s_char == csvfs_pkg::BACKSLASH_CODE) begin
                    cmd.s0_char = s_char;
                    do_plain    = 1'b0;
                end else begin
                    cmd.s0_char = csvfs_pkg::BACKSLASH_CODE;
                end
            end
            if (do_plain) begin
                // Separator wins over quote, quote over backslash.
                if (!in_quotes_reg && s_char == sep_reg) begin
                    p_v    = kept;
                    p_kind = csvfs_pkg::KIND_FIELD_END;
                    if (fc_reg != 6'd63) begin
                        fc_next = fc_plus[5:0];
                    end
                end else if (s_char == quote_reg) begin
                    in_quotes_next = !in_quotes_reg;
                end else if (s_char == csvfs_pkg::BACKSLASH_CODE) begin
                    esc_next = 1'b1;
                end else begin
                    p_v    = kept;
                    p_char = s_char;
                end
                if (esc_reg) begin
                    cmd.s1_v    = p_v;
                    cmd.s1_kind = p_kind;
                    cmd.s1_char = p_char;
                end else begin
                    cmd.s0_v    = p_v;
                    cmd.s0_kind = p_kind;
                    cmd.s0_char = p_char;
                end
            end
        end else if (started_reg) begin
            // A backslash still pending at line end is kept literally.
            cmd.s0_v      = esc_reg && kept;
            cmd.s0_char   = csvfs_pkg::BACKSLASH_CODE;
            cmd.s1_v      = kept;
            cmd.s1_kind   = csvfs_pkg::KIND_FIELD_END;
            cmd.pad_idx   = fc_plus[4:0];
            if (no_err && check_reg && (fc_plus < {1'b0, eff_exp})) begin
                cmd.pad_cnt = eff_exp - 6'd1 - fc_reg;
            end
            cmd.line_end  = 1'b1;
            cmd.quote_err = in_quotes_reg;
            in_quotes_next = 1'b0;
            esc_next       = 1'b0;
            fc_next        = 6'd0;
            started_next   = 1'b0;
        end
    end

    assign has_results = cmd.s0_v || cmd.s1_v || cmd.line_end;
    assign push_o      = accept && has_results;
    assign cmd_o       = cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_quotes_reg <= 1'b0;
            esc_reg       <= 1'b0;
            fc_reg        <= 6'd0;
            started_reg   <= 1'b0;
        end else if (accept) begin
            in_quotes_reg <= in_quotes_next;
            esc_reg       <= esc_next;
            fc_reg        <= fc_next;
            started_reg   <= started_next;
        end
    end

endmodule

// ===== rtl/csvfs_cmd_queue.sv =====
// Short register queue of classified items between front and back end.
`timescale 1ns / 1ps
`include "csv_line_field_splitter_unit_assert.svh"
module csvfs_cmd_queue #(
    parameter int DEPTH = csvfs_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push_i,
    input  csvfs_pkg::cmd_t data_i,
    output logic            full_o,
    input  logic            pop_i,
    output logic            valid_o,
    output csvfs_pkg::cmd_t data_o
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    csvfs_pkg::cmd_t      entry_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     count_reg, count_next;

    assign full_o  = (count_reg == FULL_CNT);
    assign valid_o = (count_reg != '0);
    assign data_o  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_i) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop_i) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push_i && !pop_i) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop_i && !push_i) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_i) begin
            entry_reg[wr_ptr_reg] <= data_i;
        end
    end

    `CSVFS_ASSERT_IMPLY(a_no_push_full, aclk, aresetn, full_o, !push_i)
    `CSVFS_ASSERT_IMPLY(a_no_pop_empty, aclk, aresetn, !valid_o, !pop_i)
    `CSVFS_ASSERT_NEXT(a_last_pop_empties, aclk, aresetn,
        pop_i && !push_i && count_reg == CNT_W'(1), !valid_o)

endmodule

// ===== rtl/csvfs_back.sv =====
// Back end: expands queued items into results behind an output register.
`timescale 1ns / 1ps
`include "csv_line_field_splitter_unit_assert.svh"
module csvfs_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid_i,
    input  csvfs_pkg::cmd_t   q_data_i,
    output logic              pop_o,
    output logic              m_tvalid,
    input  logic              m_tready,
    output csvfs_pkg::kind_t  m_kind,
    output logic [7:0]        m_char,
    output logic [4:0]        m_index,
    output logic              m_err,
    output logic              m_tlast
);

    csvfs_pkg::cmd_t  cur_reg, cur_next, cleared;
    logic             have, rem, out_free, emit, load;
    csvfs_pkg::kind_t pick_kind;
    logic [7:0]       pick_char;
    logic [4:0]       pick_idx;
    logic             pick_err;

    logic             out_valid_reg, out_valid_next;
    csvfs_pkg::kind_t out_kind_reg, out_kind_next;
    logic [7:0]       out_char_reg, out_char_next;
    logic [4:0]       out_idx_reg, out_idx_next;
    logic             out_err_reg, out_err_next;
    logic             out_last_reg, out_last_next;

    assign have = cur_reg.s0_v || cur_reg.s1_v || (cur_reg.pad_cnt != 6'd0) ||
                  cur_reg.line_end;

    // Picks the next result of the current item and what is left after it.
    always_comb begin
        cleared   = cur_reg;
        pick_kind = csvfs_pkg::KIND_LINE_END;
        pick_char = 8'd0;
        pick_idx  = 5'd0;
        pick_err  = 1'b0;
        rem       = 1'b0;
        if (cur_reg.s0_v) begin
            pick_kind    = cur_reg.s0_kind;
            pick_char    = cur_reg.s0_char;
            pick_idx     = cur_reg.idx;
            cleared.s0_v = 1'b0;
            rem = cur_reg.s1_v || (cur_reg.pad_cnt != 6'd0) || cur_reg.line_end;
        end else if (cur_reg.s1_v) begin
            pick_kind    = cur_reg.s1_kind;
            pick_char    = cur_reg.s1_char;
            pick_idx     = cur_reg.idx;
            cleared.s1_v = 1'b0;
            rem = (cur_reg.pad_cnt != 6'd0) || cur_reg.line_end;
        end else if (cur_reg.pad_cnt != 6'd0) begin
            pick_kind       = csvfs_pkg::KIND_FIELD_END;
            pick_idx        = cur_reg.pad_idx;
            cleared.pad_cnt = cur_reg.pad_cnt - 6'd1;
            cleared.pad_idx = cur_reg.pad_idx + 5'd1;
            rem = (cur_reg.pad_cnt != 6'd1) || cur_reg.line_end;
        end else begin
            pick_err         = cur_reg.quote_err;
            cleared.line_end = 1'b0;
        end
    end

    assign out_free = !out_valid_reg || m_tready;
    assign emit     = have && out_free;
    // The next item is loaded as soon as the current one gives its last result.
    assign load     = q_valid_i && (!have || (emit && !rem));
    assign pop_o    = load;

    always_comb begin
        if (load) begin
            cur_next = q_data_i;
        end else if (emit) begin
            cur_next = cleared;
        end else begin
            cur_next = cur_reg;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_char_next  = out_char_reg;
        out_idx_next   = out_idx_reg;
        out_err_next   = out_err_reg;
        out_last_next  = out_last_reg;
        if (out_free) begin
            out_valid_next = emit;
            out_kind_next  = pick_kind;
            out_char_next  = pick_char;
            out_idx_next   = pick_idx;
            out_err_next   = pick_err;
            out_last_next  = !rem;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            cur_reg       <= cur_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_kind_reg <= out_kind_next;
        out_char_reg <= out_char_next;
        out_idx_reg  <= out_idx_next;
        out_err_reg  <= out_err_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_kind   = out_kind_reg;
    assign m_char   = out_char_reg;
    assign m_index  = out_idx_reg;
    assign m_err    = out_err_reg;
    assign m_tlast  = out_last_reg;

    `CSVFS_ASSERT_IMPLY(a_line_end_clean, aclk, aresetn,
        m_tvalid && m_kind == csvfs_pkg::KIND_LINE_END,
        m_tlast && m_char == 8'd0 && m_index == 5'd0)
    `CSVFS_ASSERT_IMPLY(a_field_end_no_char, aclk, aresetn,
        m_tvalid && m_kind == csvfs_pkg::KIND_FIELD_END, m_char == 8'd0 && !m_err)
    `CSVFS_ASSERT_NEXT(a_run_unbroken, aclk, aresetn,
        m_tvalid && m_tready && !m_tlast, m_tvalid)

endmodule

// ===== rtl/csv_line_field_splitter_unit.sv =====
// Top level of the CSV line field splitter.
//
//  port group   dir   payload
//  s_*          in    tdata[7:0] character, tlast end of line
//  m_*          out   tdata character/field index/quote error, tuser kind,
//                     tlast final result of the request
//  cfg_*        in    register writes, index 0..3, 8-bit data
//
// The front end takes one request per cycle while s_tready is high; the back end
// emits one result per cycle while it holds results and its output is free (up to 34
// on a padded line end), a rate set by the single output register it emits through.
// The front end keeps taking requests until the command queue (QUEUE_DEPTH entries)
// fills, so short bursts hide. Reset is synchronous; there is no clearing pass. A
// result passes through the command queue, the current-item register and the output register.
`timescale 1ns / 1ps
module csv_line_field_splitter_unit #(
    parameter int MAX_COLUMNS = csvfs_pkg::MAX_COLUMNS_DEFAULT,
    parameter int QUEUE_DEPTH = csvfs_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_char, [12:8] field_index, [13] quote_error
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast
);

    logic             push, pop, q_full, q_valid;
    csvfs_pkg::cmd_t  push_cmd, head_cmd;
    csvfs_pkg::kind_t out_kind;
    logic [7:0]       out_char;
    logic [4:0]       out_idx;
    logic             out_err;

    csvfs_front #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_char    (s_tdata),
        .s_eol     (s_tlast),
        .q_full_i  (q_full),
        .push_o    (push),
        .cmd_o     (push_cmd)
    );

    csvfs_cmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push_i  (push),
        .data_i  (push_cmd),
        .full_o  (q_full),
        .pop_i   (pop),
        .valid_o (q_valid),
        .data_o  (head_cmd)
    );

    csvfs_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid_i (q_valid),
        .q_data_i  (head_cmd),
        .pop_o     (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_kind    (out_kind),
        .m_char    (out_char),
        .m_index   (out_idx),
        .m_err     (out_err),
        .m_tlast   (m_tlast)
    );

    assign m_tdata = {2'b00, out_err, out_idx, out_char};
    assign m_tuser = out_kind;

endmodule

// ===== bench/tb_csv_line_field_splitter_unit.sv =====
// Self-checking testbench of the CSV line field splitter: directed table, random lines.
`timescale 1ns / 1ps
module tb_csv_line_field_splitter_unit;
    import csvfs_pkg::*;

    localparam int MAX_COLS    = MAX_COLUMNS_DEFAULT;
    localparam int COL_CAP     = (MAX_COLS < 32) ? MAX_COLS : 32;
    localparam int IDLE_GUARD  = 16;
    localparam int END_CYCLES  = 20;
    localparam int DRAIN_LIMIT = 20000;

    typedef struct {
        kind_t      kind;
        logic [7:0] ch;
        logic [4:0] idx;
        logic       err;
        logic       last;
    } split_result_t;

    typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

    // A register write or one request; typed rows carry the single result they cause.
    typedef struct packed {
        row_kind_t  op;
        cfg_idx_t   addr;
        logic [7:0] data;
        logic       eol;
        logic       typed;
        kind_t      kind;
        logic [7:0] xch;
        logic [4:0] xidx;
        logic       xerr;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [1:0]  cfg_addr;
    logic [7:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] char_code
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [7:0] out_char, [12:8] field_index, [13] quote_error
    logic [1:0]  m_tuser;   // [1:0] kind
    logic        m_tlast;

    csv_line_field_splitter_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Shadow copy of the registers and of the splitter state.
    logic [7:0] sep_q   = SEPARATOR_RESET;
    logic [7:0] quo_q   = QUOTE_RESET;
    logic       chk_q   = CHECK_RESET;
    logic [5:0] cols_q  = EXPECTED_RESET;
    logic       in_q    = 1'b0;
    logic       esc_q   = 1'b0;
    logic [5:0] fcount  = 6'd0;
    logic       started = 1'b0;

    split_result_t request_results[$];
    split_result_t due_results[$];
    split_result_t typed_result;
    split_result_t head_result;
    int            fail_count = 0;
    bit            send_burst = 1'b0;
    bit            recv_burst = 1'b0;
    int unsigned   recv_stall;

    stim_row_t directed_rows [34] = '{
        // Empty line right after reset.
        '{ROW_ITEM, CFG_SEPARATOR, 8'h00, 1'b1, 1'b0, KIND_CHAR,      8'h00, 5'd0, 1'b0},
        '{ROW_ITEM, CFG_SEPARATOR, 8'h61, 1'b0, 1'b1, KIND_CHAR,      8'h61, 5'd0, 1'b0},
        '{ROW_ITEM, CFG_SEPARATOR, 8'h2C, 1'b0, 1'b1, KIND_FIELD_END, 8'h00, 5'd0, 1'b0},
        // Surplus field is dropped, so the line end comes alone.
        '{ROW_ITEM, CFG_SEPARATOR, 8'h62, 1'b0, 1'b0, KIND_CHAR,      8'h00, 5'd0, 1'b0},
        '{ROW_ITEM, CFG_SEPARATOR, 8'h00, 1'b1, 1'b1, KIND_LINE_END,  8'h00, 5'd0, 1'b0},
        // Unclosed quote.
        '{ROW_ITEM, CFG_SEPARATOR, 8'h22, 1'b0, 1'b0, KIND_CHAR,      8'h00, 5'd0, 1'b0},
        '{ROW_ITEM, CFG_SEPARATOR, 8'h00, 1'b1, 1'b0, KIND_CHAR,      8'h00, 5'd0, 1'b0},
        '{ROW_CFG,  CFG_EXPECTED,  8'd3,  1'b0, 1'b0, KIND_CHAR,      8'h00, 5'd0, 1'b0},
        // Escapes: quote, backslash, other character, then the extreme byte values.
        '{ROW_ITEM, CFG_SEPARATOR, 8'h5C, 1'b0, 1'b0, KIND_CHAR,      8'h00, 5'd0, 1'b0},
        '{ROW_ITEM, CFG_SEPARATOR, 8'h22, 1'b0, 1'b1, KIND_CHAR,      8'h22, 5'd0, 1'b0},
        '{ROW_ITEM, CFG_SEPARATOR, 8'h5C, 1'b0, 1'b0, KIND_CHAR,      8'h00, 5'd0, 1'b0},
        '{ROW_ITEM, CFG_SEPARATOR, 8'h5C, 1'b0, 1'b1, KIND_CHAR,      8'h5C, 5'd0, 1'b0},
        '{ROW_ITEM, CFG_SEPARATOR, 8'h5C, 1'b0, 1'b0, KIND_CHAR,      8'h00, 5'd0, 1'b0},
        '{ROW_ITEM, CFG_SEPARATOR, 8'h78, 1'b0, 1'b0, KIND_CHAR,      8'h00, 5'd0, 1'b0},
        '{ROW_ITEM, CFG_SEPARATOR, 8'hFF, 1'b0, 1'b1, KIND_CHAR,      8'hFF, 5'd0, 1'b0},
        '{ROW_ITEM, CFG_SEPARATOR, 8'h00, 1'b0, 1'b1, KIND_CHAR,      8'h00, 5'd0, 1'b0},
        // Trailing backslash, then padding up to three fields.
        '{ROW_ITEM, CFG_SEPARATOR, 8'h5C, 1'b0, 1'b0, KIND_CHAR,      8'h00, 5'd0, 1'b0},
        '{ROW_ITEM, CFG_SEPARATOR, 8'hA5, 1'b1, 1'b0, KIND_CHAR,      8'h00, 5'd0, 1'b0},
        '{ROW_CFG,  CFG_SEPARATOR, 8'hFF, 1'b0, 1'b0, KIND_CHAR,      8'h00, 5'd0, 1'b0},
        '{ROW_CFG,  CFG_QUOTE,     8'h00, 1'b0, 1'b0, KIND_CHAR,      8'h00, 5'd0, 1'b0},
        '{ROW_CFG,  CFG_CHECK,     8'h00, 1'b0, 1'b0, KIND_CHAR,      8'h00, 5'd0, 1'b0},
        '{ROW_CFG,  CFG_EXPECTED,  8'd0,  1'b0, 1'b0, KIND_CHAR,      8'h00, 5'd0, 1'b0},
        '{ROW_ITEM, CFG_SEPARATOR, 8'hFF, 1'b0, 1'b1, KIND_FIELD_END, 8'h00, 5'd0, 1'b0},
        '{ROW_ITEM, CFG_SEPARATOR, 8'h00, 1'b0, 1'b0, KIND_CHAR,      8'h00, 5'd0, 1'b0},
        '{ROW_ITEM, CFG_SEPARATOR, 8'hFF, 1'b0, 1'b1, KIND_CHAR,      8'hFF, 5'd1, 1'b0},
        '{ROW_ITEM, CFG_SEPARATOR, 8'h00, 1'b0, 1'b0, KIND_CHAR,      8'h00, 5'd0, 1'b0},
        '{ROW_ITEM, CFG_SEPARATOR, 8'h00, 1'b1, 1'b0, KIND_CHAR,      8'h00, 5'd0, 1'b0},
        // Separator, quote and backslash share one code; the separator wins.
        '{ROW_CFG,  CFG_SEPARATOR, 8'h5C, 1'b0, 1'b0, KIND_CHAR,      8'h00, 5'd0, 1'b0},
        '{ROW_CFG,  CFG_QUOTE,     8'h5C, 1'b0, 1'b0, KIND_CHAR,      8'h00, 5'd0, 1'b0},
        '{ROW_CFG,  CFG_CHECK,     8'h01, 1'b0, 1'b0, KIND_CHAR,      8'h00, 5'd0, 1'b0},
        '{ROW_CFG,  CFG_EXPECTED,  8'd63, 1'b0, 1'b0, KIND_CHAR,      8'h00, 5'd0, 1'b0},
        '{ROW_ITEM, CFG_SEPARATOR, 8'h5C, 1'b0, 1'b1, KIND_FIELD_END, 8'h00, 5'd0, 1'b0},
        '{ROW_ITEM, CFG_SEPARATOR, 8'h61, 1'b0, 1'b1, KIND_CHAR,      8'h61, 5'd1, 1'b0},
        '{ROW_ITEM, CFG_SEPARATOR, 8'h00, 1'b1, 1'b0, KIND_CHAR,      8'h00, 5'd0, 1'b0}
    };

    function automatic int unsigned eff_cols();
        int unsigned e;
        e = {26'd0, cols_q};
        if (e < 1) e = 1;
        if (e > COL_CAP) e = COL_CAP;
        return e;
    endfunction

    function automatic logic field_kept();
        return !chk_q || ({26'd0, fcount} < eff_cols());
    endfunction

    function automatic logic [4:0] field_idx();
        return (fcount > 6'd31) ? 5'd31 : fcount[4:0];
    endfunction

    task automatic add_result(kind_t k, logic [7:0] c, logic [4:0] i, logic e);
        split_result_t r;
        r.kind = k;
        r.ch   = c;
        r.idx  = i;
        r.err  = e;
        r.last = 1'b0;
        request_results.insert(request_results.size(), r);
    endtask

    task automatic put_char(logic [7:0] c);
        if (field_kept()) add_result(KIND_CHAR, c, field_idx(), 1'b0);
    endtask

    task automatic close_field();
        if (field_kept()) add_result(KIND_FIELD_END, 8'h00, field_idx(), 1'b0);
        if (fcount < 6'd63) fcount = fcount + 6'd1;
    endtask

    task automatic take_plain(logic [7:0] c);
        if (!in_q && c == sep_q) begin
            close_field();
        end else if (c == quo_q) begin
            in_q = !in_q;
        end else if (c == BACKSLASH_CODE) begin
            esc_q = 1'b1;
        end else begin
            put_char(c);
        end
    endtask

    // Works out the results of one accepted request and advances the shadow state.
    task automatic split_request(logic [7:0] c, logic eol);
        logic err;
        request_results.delete();
        if (!eol) begin
            started = 1'b1;
            if (esc_q) begin
                esc_q = 1'b0;
                if (c == quo_q || c == BACKSLASH_CODE) begin
                    put_char(c);
                end else begin
                    put_char(BACKSLASH_CODE);
                    take_plain(c);
                end
            end else begin
                take_plain(c);
            end
        end else if (started) begin
            err = in_q;
            if (esc_q) put_char(BACKSLASH_CODE);
            close_field();
            if (!err && chk_q) begin
                while ({26'd0, fcount} < eff_cols()) close_field();
            end
            add_result(KIND_LINE_END, 8'h00, 5'd0, err);
            in_q    = 1'b0;
            esc_q   = 1'b0;
            fcount  = 6'd0;
            started = 1'b0;
        end
        if (request_results.size() > 0)
            request_results[request_results.size() - 1].last = 1'b1;
    endtask

    task automatic send_char(logic [7:0] c, logic eol, bit use_typed);
        int unsigned gap;
        gap = send_burst ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eol;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        split_request(c, eol);
        if (use_typed) begin
            due_results.insert(due_results.size(), typed_result);
        end else begin
            foreach (request_results[i])
                due_results.insert(due_results.size(), request_results[i]);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (due_results.size() != 0) @(posedge aclk);
    endtask

    // A request without results may still be in flight, hence the extra cycles.
    task automatic write_reg(cfg_idx_t a, logic [7:0] v);
        drain();
        repeat (IDLE_GUARD) @(posedge aclk);
        case (a)
            CFG_SEPARATOR: sep_q = v;
            CFG_QUOTE:     quo_q = v;
            CFG_CHECK:     chk_q = v[0];
            CFG_EXPECTED:  cols_q = v[5:0];
            default: ;
        endcase
        cfg_wr_en <= 1'b1;
        cfg_addr  <= a;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Random lines: mostly separators, quotes, backslashes and arbitrary bytes.
    task automatic random_phase(logic [7:0] sep, logic [7:0] quo, logic chk, logic [5:0] cols,
                                int n_items, int sep_w, int max_len, bit hold_mid);
        int         sent;
        int         len;
        int         r;
        bit         held;
        logic [7:0] c;
        write_reg(CFG_SEPARATOR, sep);
        write_reg(CFG_QUOTE, quo);
        write_reg(CFG_CHECK, {7'd0, chk});
        write_reg(CFG_EXPECTED, {2'd0, cols});
        sent = 0;
        held = 1'b0;
        while (sent < n_items) begin
            send_burst = ($urandom_range(0, 3) == 0);
            len = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, max_len);
            for (int i = 0; i < len; i++) begin
                r = $urandom_range(0, 99);
                if (r < sep_w) c = sep;
                else if (r < sep_w + 10) c = quo;
                else if (r < sep_w + 20) c = BACKSLASH_CODE;
                else c = 8'($urandom_range(0, 255));
                send_char(c, 1'b0, 1'b0);
                sent++;
            end
            send_char(8'($urandom_range(0, 255)), 1'b1, 1'b0);
            sent++;
            if (hold_mid && !held && sent >= n_items / 2) begin
                drain();
                held = 1'b1;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (due_results.size() == 0) begin
                if (fail_count < 10)
                    $display("unexpected result: tdata %h tuser %0d tlast %0b",
                             m_tdata, m_tuser, m_tlast);
                fail_count++;
            end else begin
                head_result = due_results.pop_front();
                if ({m_tdata, m_tuser, m_tlast} !== {2'b00, head_result.err, head_result.idx,
                                                     head_result.ch, head_result.kind,
                                                     head_result.last}) begin
                    if (fail_count < 10)
                        $display("mismatch: expected kind %0d char %h idx %0d err %0b last %0b, %s",
                                 head_result.kind, head_result.ch, head_result.idx,
                                 head_result.err, head_result.last, "got:");
                    if (fail_count < 10)
                        $display("          tuser %0d char %h idx %0d err %0b last %0b tdata %h",
                                 m_tuser, m_tdata[7:0], m_tdata[12:8], m_tdata[13], m_tlast,
                                 m_tdata);
                    fail_count++;
                end
            end
        end
    end

    // Result side: a random stall before each result, with stall-free stretches.
    initial begin
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if ($urandom_range(0, 15) == 0) recv_burst = !recv_burst;
            recv_stall = recv_burst ? 0 : $urandom_range(0, 8);
            if (recv_stall != 0) begin
                m_tready <= 1'b0;
                repeat (recv_stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    initial begin
        int guard;
        s_tvalid  = 1'b0;
        s_tdata   = 8'h00;
        s_tlast   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr  = CFG_SEPARATOR;
        cfg_wdata = 8'h00;
        aresetn   = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].op == ROW_CFG) begin
                write_reg(directed_rows[i].addr, directed_rows[i].data);
            end else begin
                typed_result.kind = directed_rows[i].kind;
                typed_result.ch   = directed_rows[i].xch;
                typed_result.idx  = directed_rows[i].xidx;
                typed_result.err  = directed_rows[i].xerr;
                typed_result.last = 1'b1;
                send_burst = ($urandom_range(0, 3) == 0);
                send_char(directed_rows[i].data, directed_rows[i].eol, directed_rows[i].typed);
            end
        end

        random_phase(8'h2C, 8'h22, 1'b1, 6'($urandom_range(1, 6)), 15, 20, 12, 1'b0);
        // Unchecked lines with many separators push the field index into saturation.
        random_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0,
                     6'($urandom_range(0, 63)), 25, 70, 40, 1'b0);
        random_phase(8'h3B, 8'h27, 1'b1, 6'd32, 15, 25, 10, 1'b1);
        random_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b1, 6'd0,
                     10, 25, 8, 1'b0);

        s_tvalid <= 1'b0;
        guard = 0;
        while (due_results.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
        repeat (END_CYCLES) @(posedge aclk);
        if (due_results.size() != 0) begin
            $display("%0d expected results never arrived", due_results.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
